### hw/rtl/ppm_pkg.sv
// Shared widths, codes and reset values for the pen point mapper.
package ppm_pkg;

  localparam int PEN_COORD_BITS = 16;
  localparam int SCR_W  = 14;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 3;
  localparam int FUNC_W = 2;
  localparam int ACT_W  = 3;
  localparam int CW     = PEN_COORD_BITS + 5;
  localparam int DW     = PEN_COORD_BITS + 2;
  localparam int QW     = SCR_W;
  localparam int PW     = DW + QW;
  localparam int CNT_W  = 4;

  localparam logic [SCR_W-1:0] SCR_MAX  = SCR_W'(8191);
  localparam logic [SCR_W-1:0] SCR_NONE = '1;

  localparam logic [FUNC_W-1:0] FN_DOWN = 2'd0;
  localparam logic [FUNC_W-1:0] FN_MOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_UP   = 2'd2;

  localparam logic [ACT_W-1:0] ACT_NONE       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_CLICK      = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DRAG_START = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DRAG_MOVE  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DRAG_END   = 3'd4;

  localparam logic [IDX_W-1:0] REG_CAL_FIRST_X  = 3'd0;
  localparam logic [IDX_W-1:0] REG_CAL_FIRST_Y  = 3'd1;
  localparam logic [IDX_W-1:0] REG_CAL_SECOND_X = 3'd2;
  localparam logic [IDX_W-1:0] REG_CAL_SECOND_Y = 3'd3;
  localparam logic [IDX_W-1:0] REG_SCREEN_W     = 3'd4;
  localparam logic [IDX_W-1:0] REG_SCREEN_H     = 3'd5;
  localparam logic [IDX_W-1:0] REG_DRAG_LIMIT   = 3'd6;

  localparam logic [CFG_W-1:0] DRAG_LIMIT_RST = CFG_W'(100);

  typedef logic signed [CW-1:0] coord_t;

endpackage

### hw/rtl/pen_point_mapper_with_drag_detect.sv
// Top level of the pen point mapper: box derivation, serial map and drag classification.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_func, in_pen_x, in_pen_y
//  out     | output    | out_valid / out_ready| out_screen_x, out_screen_y, out_action
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item at a time: in_ready is high only in S_IDLE. S_DIFF, S_MARG, S_BOX, S_ORG,
// S_DIST and S_CHK derive the box and check the point, then a bit-serial multiply and a
// restoring divide run in turn, both axes side by side.
// Reset is synchronous and active low; configuration writes are always taken.
// A new item is taken while the previous result still waits in the output register.
module pen_point_mapper_with_drag_detect import ppm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [FUNC_W-1:0]        in_func,
  input  logic [15:0]              in_pen_x,
  input  logic [15:0]              in_pen_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [SCR_W-1:0]  out_screen_x,
  output logic signed [SCR_W-1:0]  out_screen_y,
  output logic [ACT_W-1:0]         out_action,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIFF = 4'd1;
  localparam logic [3:0] S_MARG = 4'd2;
  localparam logic [3:0] S_BOX  = 4'd3;
  localparam logic [3:0] S_ORG  = 4'd4;
  localparam logic [3:0] S_DIST = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QW - 1);

  logic [3:0]                state_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [PEN_COORD_BITS-1:0] cal_fx_r, cal_fy_r, cal_sx_r, cal_sy_r;
  logic [SCR_W-1:0]          scr_r [2];
  logic [CFG_W-1:0]          limit_r;
  logic [PEN_COORD_BITS-1:0] down_x_r, down_y_r;
  logic                      drag_r;
  logic [FUNC_W-1:0]         func_r;
  logic [PEN_COORD_BITS-1:0] pen_r [2];
  logic [ACT_W-1:0]          act_r;
  coord_t                    span_r [2];
  coord_t                    marg_r [2];
  coord_t                    org_r  [2];
  coord_t                    dist_r [2];
  logic                      ok_r   [2];
  logic [PW-1:0]             acc_r  [2];
  logic [PW-1:0]             mcand_r[2];
  logic [SCR_W-1:0]          mplr_r [2];
  logic [PW-1:0]             dsor_r [2];
  logic [QW-1:0]             quo_r  [2];
  logic                      out_valid_r;
  logic [SCR_W-1:0]          out_x_r, out_y_r;
  logic [ACT_W-1:0]          out_act_r;

  logic [PEN_COORD_BITS-1:0] adx, ady;
  logic                      far;
  logic                      out_load;
  coord_t                    marg_nxt [2];
  coord_t                    c1x, c1y, c2x, c2y;
  logic [SCR_W-1:0]          sat_x, sat_y;

  assign c1x = coord_t'({5'b0, cal_fx_r});
  assign c1y = coord_t'({5'b0, cal_fy_r});
  assign c2x = coord_t'({5'b0, cal_sx_r});
  assign c2y = coord_t'({5'b0, cal_sy_r});

  assign adx = (down_x_r >= pen_r[0]) ? down_x_r - pen_r[0] : pen_r[0] - down_x_r;
  assign ady = (down_y_r >= pen_r[1]) ? down_y_r - pen_r[1] : pen_r[1] - down_y_r;
  assign far = (adx > limit_r) || (ady > limit_r);

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      marg_nxt[l] = (span_r[l] + coord_t'({3{span_r[l][CW-1]}})) >>> 3;
    end
  end

  assign sat_x = quo_r[0][QW-1] ? SCR_MAX : quo_r[0];
  assign sat_y = quo_r[1][QW-1] ? SCR_MAX : quo_r[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      drag_r      <= 1'b0;
      down_x_r    <= '0;
      down_y_r    <= '0;
      cal_fx_r    <= '0;
      cal_fy_r    <= '0;
      cal_sx_r    <= '0;
      cal_sy_r    <= '0;
      scr_r[0]    <= '0;
      scr_r[1]    <= '0;
      limit_r     <= DRAG_LIMIT_RST;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_CAL_FIRST_X:  cal_fx_r <= cfg_data;
          REG_CAL_FIRST_Y:  cal_fy_r <= cfg_data;
          REG_CAL_SECOND_X: cal_sx_r <= cfg_data;
          REG_CAL_SECOND_Y: cal_sy_r <= cfg_data;
          REG_SCREEN_W:     scr_r[0] <= cfg_data[SCR_W-1:0];
          REG_SCREEN_H:     scr_r[1] <= cfg_data[SCR_W-1:0];
          REG_DRAG_LIMIT:   limit_r  <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            func_r   <= in_func;
            pen_r[0] <= in_pen_x;
            pen_r[1] <= in_pen_y;
            state_r  <= S_DIFF;
          end
        end
        S_DIFF: begin
          span_r[0] <= (c2x - c1x) <<< 1;
          span_r[1] <= (c1y - c2y) <<< 1;
          case (func_r)
            FN_DOWN: begin
              down_x_r <= pen_r[0];
              down_y_r <= pen_r[1];
              drag_r   <= 1'b0;
              act_r    <= ACT_NONE;
            end
            FN_MOVE: begin
              if (drag_r) begin
                act_r <= ACT_DRAG_MOVE;
              end else if (far) begin
                drag_r <= 1'b1;
                act_r  <= ACT_DRAG_START;
              end else begin
                act_r <= ACT_NONE;
              end
            end
            FN_UP: begin
              if (drag_r) begin
                drag_r <= 1'b0;
                act_r  <= ACT_DRAG_END;
              end else begin
                act_r <= ACT_CLICK;
              end
            end
            default: act_r <= ACT_NONE;
          endcase
          state_r <= S_MARG;
        end
        S_MARG: begin
          marg_r[0] <= marg_nxt[0];
          marg_r[1] <= marg_nxt[1];
          state_r   <= S_BOX;
        end
        S_BOX: begin
          span_r[0] <= span_r[0] + (marg_r[0] <<< 1);
          span_r[1] <= span_r[1] + (marg_r[1] <<< 1);
          org_r[0]  <= c1x - marg_r[0];
          org_r[1]  <= c1y + marg_r[1];
          state_r   <= S_ORG;
        end
        S_ORG: begin
          org_r[1] <= org_r[1] - span_r[1];
          state_r  <= S_DIST;
        end
        S_DIST: begin
          for (int l = 0; l < 2; l++) begin
            dist_r[l] <= coord_t'({5'b0, pen_r[l]}) - org_r[l];
          end
          state_r <= S_CHK;
        end
        S_CHK: begin
          for (int l = 0; l < 2; l++) begin
            ok_r[l]    <= (span_r[l] > 0) && (dist_r[l] > 0) && (dist_r[l] < span_r[l]);
            acc_r[l]   <= '0;
            mcand_r[l] <= {{(PW-DW){1'b0}}, dist_r[l][DW-1:0]};
            mplr_r[l]  <= scr_r[l];
            dsor_r[l]  <= {1'b0, span_r[l][DW-1:0], {(QW-1){1'b0}}};
          end
          cnt_r   <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          for (int l = 0; l < 2; l++) begin
            if (mplr_r[l][0]) begin
              acc_r[l] <= acc_r[l] + mcand_r[l];
            end
            mcand_r[l] <= mcand_r[l] << 1;
            mplr_r[l]  <= mplr_r[l] >> 1;
          end
          if (cnt_r == LAST_STEP) begin
            cnt_r   <= '0;
            state_r <= S_DIV;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DIV: begin
          for (int l = 0; l < 2; l++) begin
            if (acc_r[l] >= dsor_r[l]) begin
              acc_r[l] <= acc_r[l] - dsor_r[l];
              quo_r[l] <= {quo_r[l][QW-2:0], 1'b1};
            end else begin
              quo_r[l] <= {quo_r[l][QW-2:0], 1'b0};
            end
            dsor_r[l] <= dsor_r[l] >> 1;
          end
          if (cnt_r == LAST_STEP) begin
            cnt_r   <= '0;
            state_r <= S_DONE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_x_r   <= (ok_r[0] && ok_r[1]) ? sat_x : SCR_NONE;
            out_y_r   <= (ok_r[0] && ok_r[1]) ? sat_y : SCR_NONE;
            out_act_r <= act_r;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready     = (state_r == S_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_screen_x = $signed(out_x_r);
  assign out_screen_y = $signed(out_y_r);
  assign out_action   = out_act_r;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_DIFF)
    else $error("accepted item did not start the box derivation");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside the final step");

  a_drag_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(drag_r) |-> act_r == ACT_DRAG_START)
    else $error("dragging began without a drag start action");
`endif

endmodule

### tb/pen_point_mapper_with_drag_detect_test.sv
// Self-checking testbench for the pen point mapper with drag detection.
module pen_point_mapper_with_drag_detect_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ppm_pkg::*;

  localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;
  localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int DIR_ROWS = 37;
  localparam int PHASES = 8;
  localparam int EVENTS_PER_PHASE = 85;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic signed [SCR_W-1:0] sx;
    logic signed [SCR_W-1:0] sy;
    logic [ACT_W-1:0] act;
  } pen_result_t;

  typedef struct {
    bit is_cfg;
    logic [IDX_W-1:0] idx;
    logic [FUNC_W-1:0] fn;
    logic [15:0] a;
    logic [15:0] b;
    bit known;
    pen_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [FUNC_W-1:0] in_func;
  logic [15:0] in_pen_x;
  logic [15:0] in_pen_y;
  logic out_valid;
  logic out_ready;
  logic signed [SCR_W-1:0] out_screen_x;
  logic signed [SCR_W-1:0] out_screen_y;
  logic [ACT_W-1:0] out_action;
  logic cfg_valid;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  logic [15:0] reg_copy [0:7];
  logic [15:0] down_x_seen;
  logic [15:0] down_y_seen;
  bit drag_on;

  pen_result_t due_results[$];
  pen_result_t lit_res;
  pen_result_t blank_res;
  bit lit_known;
  stim_row_t dir_rows [DIR_ROWS];

  int in_gap_pct = 20;
  int out_gap_pct = 10;
  int fail_count = 0;
  int sent_events = 0;
  int reg_writes = 0;
  int drag_starts = 0;
  int drag_ends = 0;
  int stall_cycles = 0;

  pen_point_mapper_with_drag_detect DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_func(in_func),
    .in_pen_x(in_pen_x),
    .in_pen_y(in_pen_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_screen_x(out_screen_x),
    .out_screen_y(out_screen_y),
    .out_action(out_action),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [SCR_W-1:0] map_axis_pred(longint p, longint o, longint b,
                                                             longint s, inout bit ok);
    longint q;
    if (!(p > o && p < o + b) || b <= 0) begin
      ok = 1'b0;
      return '0;
    end
    q = ((p - o) * s) / b;
    if (q > longint'(SCR_MAX)) q = longint'(SCR_MAX);
    return q[SCR_W-1:0];
  endfunction

  function automatic longint span(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic pen_result_t map_and_classify(logic [FUNC_W-1:0] f, logic [15:0] x,
                                                   logic [15:0] y);
    longint c1x, c1y, c2x, c2y, dw, dh, mw, mh, bw, bh, ox, oy;
    bit ok;
    pen_result_t r;
    c1x = reg_copy[REG_CAL_FIRST_X];
    c1y = reg_copy[REG_CAL_FIRST_Y];
    c2x = reg_copy[REG_CAL_SECOND_X];
    c2y = reg_copy[REG_CAL_SECOND_Y];
    dw = (c2x - c1x) * 2;
    dh = (c1y - c2y) * 2;
    mw = dw / 8;
    mh = dh / 8;
    bw = dw + 2 * mw;
    bh = dh + 2 * mh;
    ox = c1x - mw;
    oy = c1y + mh - bh;
    ok = 1'b1;
    r.sx = map_axis_pred(x, ox, bw, reg_copy[REG_SCREEN_W][SCR_W-1:0], ok);
    r.sy = map_axis_pred(y, oy, bh, reg_copy[REG_SCREEN_H][SCR_W-1:0], ok);
    if (!ok) begin
      r.sx = SCR_NONE;
      r.sy = SCR_NONE;
    end
    r.act = ACT_NONE;
    case (f)
      FN_DOWN: begin
        down_x_seen = x;
        down_y_seen = y;
        drag_on = 1'b0;
      end
      FN_MOVE: begin
        if (drag_on) begin
          r.act = ACT_DRAG_MOVE;
        end else if (span(down_x_seen, x) > reg_copy[REG_DRAG_LIMIT] ||
                     span(down_y_seen, y) > reg_copy[REG_DRAG_LIMIT]) begin
          drag_on = 1'b1;
          r.act = ACT_DRAG_START;
        end
      end
      FN_UP: begin
        r.act = drag_on ? ACT_DRAG_END : ACT_CLICK;
        drag_on = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic stim_row_t ev_row(logic [FUNC_W-1:0] f, logic [15:0] x, logic [15:0] y);
    stim_row_t r;
    r = '{default: '0};
    r.fn = f;
    r.a = x;
    r.b = y;
    return r;
  endfunction

  function automatic stim_row_t ev_known(logic [FUNC_W-1:0] f, logic [15:0] x, logic [15:0] y,
                                         logic [ACT_W-1:0] act);
    stim_row_t r;
    r = ev_row(f, x, y);
    r.known = 1'b1;
    r.res = '{SCR_NONE, SCR_NONE, act};
    return r;
  endfunction

  function automatic stim_row_t wr_row(logic [IDX_W-1:0] idx, logic [15:0] data);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.a = data;
    return r;
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  function automatic logic [15:0] pick_in(longint a, longint b);
    logic [15:0] lo, hi;
    lo = clamp16((a < b) ? a : b);
    hi = clamp16((a < b) ? b : a);
    return 16'($urandom_range(hi, lo));
  endfunction

  function automatic logic [15:0] pick_screen();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      3: return 16'd8192;
      default: return 16'($urandom_range(1, 8192));
    endcase
  endfunction

  task automatic put_event(input logic [FUNC_W-1:0] f, input logic [15:0] x,
                           input logic [15:0] y, input bit known, input pen_result_t res);
    if (in_gap_pct != 0 && $urandom_range(1, 100) <= in_gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_func = f;
    in_pen_x = x;
    in_pen_y = y;
    lit_known = known;
    lit_res = res;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent_events++;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    in_valid = 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (out_gap_pct != 0 && $urandom_range(1, 100) <= out_gap_pct) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    pen_result_t r, want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        reg_copy[cfg_index] = cfg_data;
        reg_writes++;
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result with no pending item: screen_x %0d screen_y %0d action %0d",
                 out_screen_x, out_screen_y, out_action);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (out_screen_x !== want.sx) begin
            $error("screen_x: expected %0d, got %0d", want.sx, out_screen_x);
            fail_count++;
          end
          if (out_screen_y !== want.sy) begin
            $error("screen_y: expected %0d, got %0d", want.sy, out_screen_y);
            fail_count++;
          end
          if (out_action !== want.act) begin
            $error("action: expected %0d, got %0d", want.act, out_action);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        r = map_and_classify(in_func, in_pen_x, in_pen_y);
        if (lit_known) r = lit_res;
        if (r.act == ACT_DRAG_START) drag_starts++;
        if (r.act == ACT_DRAG_END) drag_ends++;
        due_results.push_back(r);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] plan [0:7];
    logic [15:0] px, py;
    longint wx_lo, wx_hi, wy_lo, wy_hi, stepmax, dx, dy, tmp;
    int k, moves;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FN_DOWN;
    in_pen_x = '0;
    in_pen_y = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_CAL_FIRST_X;
    cfg_data = '0;
    lit_known = 1'b0;
    blank_res = '{default: '0};
    lit_res = blank_res;
    foreach (reg_copy[i]) reg_copy[i] = '0;
    reg_copy[REG_DRAG_LIMIT] = DRAG_LIMIT_RST;
    down_x_seen = '0;
    down_y_seen = '0;
    drag_on = 1'b0;

    dir_rows = '{
      ev_known(FN_DOWN, 16'd0, 16'd0, ACT_NONE),
      ev_known(FN_MOVE, 16'd100, 16'd100, ACT_NONE),
      ev_known(FN_MOVE, 16'd101, 16'd0, ACT_DRAG_START),
      ev_known(FN_MOVE, 16'd0, 16'd0, ACT_DRAG_MOVE),
      ev_known(FN_UP, 16'hFFFF, 16'hFFFF, ACT_DRAG_END),
      ev_known(FN_UP, 16'd0, 16'd0, ACT_CLICK),
      ev_known(FN_SPARE, 16'hFFFF, 16'hFFFF, ACT_NONE),
      ev_known(FN_MOVE, 16'hFFFF, 16'hFFFF, ACT_DRAG_START),
      ev_known(FN_DOWN, 16'hFFFF, 16'hFFFF, ACT_NONE),
      ev_known(FN_UP, 16'd0, 16'd0, ACT_CLICK),
      wr_row(REG_CAL_FIRST_X, 16'd1000),
      wr_row(REG_CAL_FIRST_Y, 16'd9000),
      wr_row(REG_CAL_SECOND_X, 16'd5000),
      wr_row(REG_CAL_SECOND_Y, 16'd1000),
      wr_row(REG_SCREEN_W, 16'd1920),
      wr_row(REG_SCREEN_H, 16'd1080),
      wr_row(REG_DRAG_LIMIT, 16'd0),
      ev_row(FN_DOWN, 16'd0, 16'd0),
      ev_row(FN_DOWN, 16'd1, 16'd0),
      ev_row(FN_MOVE, 16'd1, 16'd0),
      ev_row(FN_MOVE, 16'd2, 16'd0),
      ev_row(FN_MOVE, 16'd9999, 16'd10999),
      ev_row(FN_UP, 16'd10000, 16'd5000),
      ev_row(FN_UP, 16'd5000, 16'd5000),
      wr_row(REG_CAL_FIRST_X, 16'd0),
      wr_row(REG_CAL_FIRST_Y, 16'hFFFF),
      wr_row(REG_CAL_SECOND_X, 16'hFFFF),
      wr_row(REG_CAL_SECOND_Y, 16'd0),
      wr_row(REG_SCREEN_W, 16'hFFFF),
      wr_row(REG_SCREEN_H, 16'hC000),
      wr_row(REG_DRAG_LIMIT, 16'hFFFF),
      wr_row(REG_SPARE, 16'h5A5A),
      ev_row(FN_DOWN, 16'hFFFF, 16'hFFFF),
      ev_row(FN_MOVE, 16'd0, 16'd0),
      ev_row(FN_UP, 16'd32768, 16'd0),
      wr_row(REG_CAL_FIRST_X, 16'd40000),
      ev_row(FN_DOWN, 16'd20000, 16'd20000)
    };

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_reg(dir_rows[i].idx, dir_rows[i].a);
      else put_event(dir_rows[i].fn, dir_rows[i].a, dir_rows[i].b, dir_rows[i].known,
                     dir_rows[i].res);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        foreach (plan[i]) plan[i] = 16'hFFFF;
      end else if ($urandom_range(0, 5) == 0) begin
        foreach (plan[i]) plan[i] = 16'($urandom);
      end else begin
        plan[REG_CAL_FIRST_X] = 16'($urandom_range(0, 45000));
        plan[REG_CAL_SECOND_X] = plan[REG_CAL_FIRST_X] + 16'($urandom_range(0, 20000));
        plan[REG_CAL_FIRST_Y] = 16'($urandom_range(20000, 65535));
        plan[REG_CAL_SECOND_Y] = plan[REG_CAL_FIRST_Y] - 16'($urandom_range(0, 20000));
        if ($urandom_range(0, 5) == 0) begin
          px = plan[REG_CAL_FIRST_X];
          plan[REG_CAL_FIRST_X] = plan[REG_CAL_SECOND_X];
          plan[REG_CAL_SECOND_X] = px;
        end
        plan[REG_SCREEN_W] = pick_screen();
        plan[REG_SCREEN_H] = pick_screen();
        case ($urandom_range(0, 5))
          0: plan[REG_DRAG_LIMIT] = 16'd0;
          1: plan[REG_DRAG_LIMIT] = 16'hFFFF;
          2: plan[REG_DRAG_LIMIT] = 16'($urandom);
          default: plan[REG_DRAG_LIMIT] = 16'($urandom_range(0, 400));
        endcase
      end
      in_gap_pct = (ph == PHASES - 1) ? 0 : 20 * $urandom_range(0, 2);
      out_gap_pct = (ph == PHASES - 1) ? 0 : 8 * $urandom_range(0, 2);
      for (int i = REG_CAL_FIRST_X; i <= REG_DRAG_LIMIT; i++) write_reg(IDX_W'(i), plan[i]);

      tmp = longint'(plan[REG_CAL_SECOND_X]) - longint'(plan[REG_CAL_FIRST_X]);
      wx_lo = longint'(plan[REG_CAL_FIRST_X]) - tmp / 2 - 8;
      wx_hi = longint'(plan[REG_CAL_FIRST_X]) + (5 * tmp) / 2 + 8;
      tmp = longint'(plan[REG_CAL_FIRST_Y]) - longint'(plan[REG_CAL_SECOND_Y]);
      wy_lo = longint'(plan[REG_CAL_FIRST_Y]) - (5 * tmp) / 2 - 8;
      wy_hi = longint'(plan[REG_CAL_FIRST_Y]) + tmp / 2 + 8;
      stepmax = (plan[REG_DRAG_LIMIT] > 2000) ? 3000 : 2 * longint'(plan[REG_DRAG_LIMIT]) + 3;

      k = 0;
      while (k < EVENTS_PER_PHASE) begin
        if ($urandom_range(1, 100) <= 15) begin
          put_event(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 1'b0, blank_res);
          k++;
        end else begin
          px = pick_in(wx_lo, wx_hi);
          py = pick_in(wy_lo, wy_hi);
          put_event(FN_DOWN, px, py, 1'b0, blank_res);
          k++;
          moves = $urandom_range(0, 6);
          repeat (moves) begin
            dx = $urandom_range(0, stepmax);
            dy = $urandom_range(0, stepmax);
            if ($urandom_range(0, 1)) dx = -dx;
            if ($urandom_range(0, 1)) dy = -dy;
            px = clamp16(longint'(px) + dx);
            py = clamp16(longint'(py) + dy);
            put_event(FN_MOVE, px, py, 1'b0, blank_res);
            k++;
          end
          if ($urandom_range(0, 9) != 0) begin
            put_event(FN_UP, px, py, 1'b0, blank_res);
            k++;
          end
        end
      end
    end

    in_valid = 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    $display("Ran %0d pen events (%0d drag starts, %0d drag ends) and %0d register writes,",
             sent_events, drag_starts, drag_ends, reg_writes);
    $display("over %0d calibration and screen settings, with %0d mismatches.",
             PHASES + 3, fail_count);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
